@@ rtl/spatial_inertia_pd_check_top_macros.svh @@
// Assertion macros for the inertia check block.
`ifndef SPATIAL_INERTIA_PD_CHECK_TOP_MACROS_SVH
`define SPATIAL_INERTIA_PD_CHECK_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SIPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define SIPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define SIPD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SIPD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sipd_pkg.sv @@
`timescale 1ns / 1ps
package sipd_pkg;
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int DIM        = 6;
    localparam int NUM_LOW    = 21;
    localparam int IDX_W      = 5;
    localparam int QDEPTH     = 2;

    typedef logic signed [DATA_WIDTH-1:0] word_t;
    typedef word_t [NUM_LOW-1:0] mat_t;

    localparam word_t VMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t VMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // lower-triangle packed index of (i, j), i >= j
    function automatic logic [IDX_W-1:0] tri_idx(input logic [2:0] i, input logic [2:0] j);
        logic [IDX_W-1:0] ii;
        ii = IDX_W'(i);
        return IDX_W'((ii * (ii + 1'b1)) >> 1) + IDX_W'(j);
    endfunction

    function automatic word_t sat_sub(input word_t a, input word_t b);
        logic signed [DATA_WIDTH:0] d;
        d = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};
        if (d[DATA_WIDTH] != d[DATA_WIDTH-1])
            return d[DATA_WIDTH] ? VMIN : VMAX;
        return d[DATA_WIDTH-1:0];
    endfunction

    function automatic word_t sign_sat(input logic [2*DATA_WIDTH-1:0] m, input logic neg);
        if (neg)
            return (m >= (2*DATA_WIDTH)'(VMAX) + 1'b1) ? VMIN : word_t'(-m[DATA_WIDTH-1:0]);
        return (m >= (2*DATA_WIDTH)'(VMAX)) ? VMAX : word_t'(m[DATA_WIDTH-1:0]);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] mag(input word_t a);
        return a[DATA_WIDTH-1] ? DATA_WIDTH'(-a) : DATA_WIDTH'(a);
    endfunction

    typedef struct packed {
        logic valid;
        mat_t mat;
    } job_t;
endpackage

@@ rtl/sipd_mul.sv @@
`timescale 1ns / 1ps
// Registered saturating fixed-point multiply: the product appears in the cycle after its operands.
module sipd_mul (
    input  logic clk,
    input  sipd_pkg::word_t a,
    input  sipd_pkg::word_t b,
    output sipd_pkg::word_t p
);
    import sipd_pkg::*;
    logic [2*DATA_WIDTH-1:0] prod;
    logic [2*DATA_WIDTH-1:0] sh;
    logic neg_reg;
    logic [2*DATA_WIDTH-1:0] prod_reg;
    assign prod = {{DATA_WIDTH{1'b0}}, mag(a)} * {{DATA_WIDTH{1'b0}}, mag(b)};
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        neg_reg  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
    end
    assign sh = prod_reg >> FRAC_BITS;
    assign p = sign_sat(sh, neg_reg);
endmodule

@@ rtl/sipd_div.sv @@
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module sipd_div (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sipd_pkg::word_t a,
    input  sipd_pkg::word_t b,
    output logic done,
    output sipd_pkg::word_t q
);
    import sipd_pkg::*;
    localparam int NB = DATA_WIDTH + FRAC_BITS;
    localparam int CW = $clog2(NB + 1);
    logic [NB-1:0] num_reg;
    logic [NB-1:0] quo_reg;
    logic [DATA_WIDTH:0] rem_reg;
    logic [DATA_WIDTH-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic run_reg, neg_reg, zero_reg;
    word_t a_reg;
    logic [DATA_WIDTH:0] rs;
    logic ge;
    assign rs = {rem_reg[DATA_WIDTH-1:0], num_reg[NB-1]};
    assign ge = rs >= {1'b0, den_reg};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done    <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done <= run_reg && cnt_reg == CW'(1);
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(NB);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    run_reg <= 1'b0;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= {mag(a), {FRAC_BITS{1'b0}}};
            den_reg  <= mag(b);
            rem_reg  <= '0;
            quo_reg  <= '0;
            neg_reg  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
            zero_reg <= (b == '0);
            a_reg    <= a;
        end
        else if (run_reg)
        begin
            num_reg <= num_reg << 1;
            rem_reg <= ge ? rs - {1'b0, den_reg} : rs;
            quo_reg <= {quo_reg[NB-2:0], ge};
        end
    end
    always_comb
    begin
        if (zero_reg)
            q = (a_reg == '0) ? '0 : (a_reg[DATA_WIDTH-1] ? VMIN : VMAX);
        else
            q = sign_sat((2*DATA_WIDTH)'(quo_reg), neg_reg);
    end
endmodule

@@ rtl/sipd_front.sv @@
`timescale 1ns / 1ps
// Front: take a request, form the cross block products, queue the matrix.
module sipd_front (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sipd_pkg::word_t mass,
    input  sipd_pkg::word_t inertia_xx,
    input  sipd_pkg::word_t inertia_yx,
    input  sipd_pkg::word_t inertia_yy,
    input  sipd_pkg::word_t inertia_zx,
    input  sipd_pkg::word_t inertia_zy,
    input  sipd_pkg::word_t inertia_zz,
    input  sipd_pkg::word_t cg_x,
    input  sipd_pkg::word_t cg_y,
    input  sipd_pkg::word_t cg_z,
    input  logic pop,
    output sipd_pkg::job_t head
);
    import sipd_pkg::*;
    logic [1:0] step_reg;
    logic act_reg;
    mat_t m_reg;
    mat_t m_next;
    word_t cg_reg [3];
    word_t mul_b, p;
    job_t q_reg [QDEPTH];
    logic [1:0] cnt_reg;
    logic push;
    sipd_mul u_mul (.clk(clk), .a(m_reg[tri_idx(3'd3, 3'd3)]), .b(mul_b), .p(p));
    // step 3 only drains the last product; hold cg_z on the multiplier
    assign mul_b = cg_reg[(step_reg == 2'd3) ? 2'd2 : step_reg];
    assign busy = act_reg || cnt_reg == 2'(QDEPTH);
    assign push = act_reg && step_reg == 2'd3;
    assign head = q_reg[0];
    always_comb
    begin
        m_next = m_reg;
        if (start && !busy)
        begin
            m_next = '0;
            m_next[tri_idx(3'd0, 3'd0)] = inertia_xx;
            m_next[tri_idx(3'd1, 3'd0)] = inertia_yx;
            m_next[tri_idx(3'd1, 3'd1)] = inertia_yy;
            m_next[tri_idx(3'd2, 3'd0)] = inertia_zx;
            m_next[tri_idx(3'd2, 3'd1)] = inertia_zy;
            m_next[tri_idx(3'd2, 3'd2)] = inertia_zz;
            m_next[tri_idx(3'd3, 3'd3)] = mass;
            m_next[tri_idx(3'd4, 3'd4)] = mass;
            m_next[tri_idx(3'd5, 3'd5)] = mass;
        end
        else if (act_reg)
        begin
            unique case (step_reg)
                2'd1:
                begin
                    m_next[tri_idx(3'd4, 3'd2)] = p;
                    m_next[tri_idx(3'd5, 3'd1)] = sat_sub('0, p);
                end
                2'd2:
                begin
                    m_next[tri_idx(3'd5, 3'd0)] = p;
                    m_next[tri_idx(3'd3, 3'd2)] = sat_sub('0, p);
                end
                2'd3:
                begin
                    m_next[tri_idx(3'd3, 3'd1)] = p;
                    m_next[tri_idx(3'd4, 3'd0)] = sat_sub('0, p);
                end
                default: ;
            endcase
        end
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
            step_reg <= '0;
            cnt_reg <= '0;
            for (int e = 0; e < QDEPTH; e++)
                q_reg[e].valid <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                act_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (act_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (push)
                    act_reg <= 1'b0;
            end
            // queue: shift on pop, append on push
            if (pop && !push)
            begin
                q_reg[0] <= q_reg[1];
                q_reg[1].valid <= 1'b0;
                cnt_reg <= cnt_reg - 1'b1;
            end
            else if (push && !pop)
            begin
                if (cnt_reg == 2'd0)
                    q_reg[0] <= '{valid: 1'b1, mat: m_next};
                else
                    q_reg[1] <= '{valid: 1'b1, mat: m_next};
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (push && pop)
            begin
                if (cnt_reg == 2'd1)
                    q_reg[0] <= '{valid: 1'b1, mat: m_next};
                else
                begin
                    q_reg[0] <= q_reg[1];
                    q_reg[1] <= '{valid: 1'b1, mat: m_next};
                end
            end
        end
    end
    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        if (start && !busy)
        begin
            cg_reg[0] <= cg_x;
            cg_reg[1] <= cg_y;
            cg_reg[2] <= cg_z;
        end
    end
endmodule

@@ rtl/sipd_back.sv @@
`timescale 1ns / 1ps
`include "spatial_inertia_pd_check_top_macros.svh"
// Back: LDL' sequencer over one divider and one multiplier.
module sipd_back (
    input  logic clk,
    input  logic rst_n,
    input  sipd_pkg::job_t head,
    output logic pop,
    output logic done,
    output sipd_pkg::word_t pv [6]
);
    import sipd_pkg::*;
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_WB   = 2'd3;
    logic [1:0] st_reg;
    mat_t a_reg;
    mat_t a_next;
    logic [2:0] k_reg, i_reg, j_reg;
    word_t t_reg, q, p;
    logic ddone;
    logic div_go_reg;
    // divider start is registered, so it rises in the same cycle the operands settle in a_reg
    sipd_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go_reg),
        .a(a_reg[tri_idx(i_reg, k_reg)]), .b(a_reg[tri_idx(k_reg, k_reg)]),
        .done(ddone), .q(q));
    sipd_mul u_mul (.clk(clk), .a(a_reg[tri_idx(j_reg, k_reg)]), .b(t_reg), .p(p));
    assign pop = st_reg == S_IDLE && head.valid;
    always_comb
        for (int d = 0; d < DIM; d++)
            pv[d] = a_reg[tri_idx(3'(d), 3'(d))];
    always_comb
    begin
        a_next = a_reg;
        unique case (st_reg)
            S_IDLE:
                if (head.valid)
                    a_next = head.mat;
            S_WB:
            begin
                a_next[tri_idx(i_reg, j_reg)] = sat_sub(a_reg[tri_idx(i_reg, j_reg)], p);
                if (j_reg == k_reg + 1'b1)
                    a_next[tri_idx(i_reg, k_reg)] = t_reg;
            end
            default: ;
        endcase
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            done <= 1'b0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            div_go_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                    if (head.valid)
                    begin
                        st_reg <= S_DIV;
                        div_go_reg <= 1'b1;
                    end
                S_DIV:
                    if (ddone)
                        st_reg <= S_MUL;
                S_MUL:
                    st_reg <= S_WB;
                default:
                    if (j_reg == k_reg + 1'b1)
                    begin
                        if (i_reg == k_reg + 1'b1 && k_reg == 3'd4)
                        begin
                            st_reg <= S_IDLE;
                            done <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= S_DIV;
                            div_go_reg <= 1'b1;
                        end
                    end
                    else
                        st_reg <= S_MUL;
            endcase
        end
    end
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        unique case (st_reg)
            S_IDLE:
                if (head.valid)
                begin
                    k_reg <= 3'd0;
                    i_reg <= 3'd5;
                end
            S_DIV:
                if (ddone)
                begin
                    t_reg <= q;
                    j_reg <= i_reg;
                end
            S_MUL: ;
            default:
            begin
                if (j_reg == k_reg + 1'b1)
                begin
                    if (i_reg == k_reg + 1'b1)
                    begin
                        k_reg <= k_reg + 1'b1;
                        i_reg <= 3'd5;
                    end
                    else
                        i_reg <= i_reg - 1'b1;
                end
                else
                    j_reg <= j_reg - 1'b1;
            end
        endcase
    end
    `SIPD_ASSERT_NXT(a_pop_idle, clk, rst_n, pop, st_reg == S_DIV)
    `SIPD_ASSERT_IMP(a_done_idle, clk, rst_n, done, st_reg == S_IDLE)
    `SIPD_ASSERT_IMP(a_ddone_div, clk, rst_n, ddone, st_reg == S_DIV)
endmodule

@@ rtl/spatial_inertia_pd_check_top.sv @@
`timescale 1ns / 1ps
// Spatial inertia positive-definite check.
// Request: drive the ten Q16.16 fields with start high; the request is taken
// on a rising edge where start is high and busy is low.
// The front forms the three mass-offset products on one multiplier, then
// moves the 6x6 lower triangle into a two-entry queue. The back runs the
// LDL' factorization: 15 column divisions on one bit-serial divider plus
// 35 multiply/subtract updates, each in a multiply and a write-back state.
// The back takes the next queued item only once it is idle again; the
// divider sets the rate.
// The result (pivot_0..pivot_5, positive_definite) is shown for exactly one
// cycle with done high; the receiver cannot stall it.
// busy stays high while the front is working or the queue is full.
// rst_n clears the sequencers and the queue asynchronously; no item is
// pending after reset.
module spatial_inertia_pd_check_top (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sipd_pkg::word_t mass,
    input  sipd_pkg::word_t inertia_xx,
    input  sipd_pkg::word_t inertia_yx,
    input  sipd_pkg::word_t inertia_yy,
    input  sipd_pkg::word_t inertia_zx,
    input  sipd_pkg::word_t inertia_zy,
    input  sipd_pkg::word_t inertia_zz,
    input  sipd_pkg::word_t cg_x,
    input  sipd_pkg::word_t cg_y,
    input  sipd_pkg::word_t cg_z,
    output logic done,
    output sipd_pkg::word_t pivot_0,
    output sipd_pkg::word_t pivot_1,
    output sipd_pkg::word_t pivot_2,
    output sipd_pkg::word_t pivot_3,
    output sipd_pkg::word_t pivot_4,
    output sipd_pkg::word_t pivot_5,
    output logic positive_definite
);
    import sipd_pkg::*;
    job_t head;
    logic pop;
    word_t pv [6];
    sipd_front u_front (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mass(mass), .inertia_xx(inertia_xx), .inertia_yx(inertia_yx),
        .inertia_yy(inertia_yy), .inertia_zx(inertia_zx), .inertia_zy(inertia_zy),
        .inertia_zz(inertia_zz), .cg_x(cg_x), .cg_y(cg_y), .cg_z(cg_z),
        .pop(pop), .head(head));
    sipd_back u_back (.clk(clk), .rst_n(rst_n), .head(head), .pop(pop),
        .done(done), .pv(pv));
    assign pivot_0 = pv[0];
    assign pivot_1 = pv[1];
    assign pivot_2 = pv[2];
    assign pivot_3 = pv[3];
    assign pivot_4 = pv[4];
    assign pivot_5 = pv[5];
    assign positive_definite = pv[0] > 0 && pv[1] > 0 && pv[2] > 0
        && pv[3] > 0 && pv[4] > 0 && pv[5] > 0;
endmodule
